### src/ftlg_pkg.sv
`default_nettype none

package ftlg_pkg;

    // level table geometry
    localparam int LEVELS       = 8;
    localparam int NATIVE_INDEX = 3;

    localparam int TIME_W  = 16;
    localparam int AVG_W   = 24;
    localparam int RUN_W   = 8;
    localparam int LEVEL_W = 3;
    localparam int SUM_W   = 28;
    localparam int IDX_W   = 3;

    // 4 bits hold LEVELS - 1 and NATIVE_INDEX over their whole range
    localparam int CMP_W = 4;
    localparam logic [CMP_W-1:0] LEVEL_MAX  = CMP_W'(LEVELS - 1);
    localparam logic [CMP_W-1:0] NATIVE_LVL = CMP_W'(NATIVE_INDEX);

    // divide by ten: floor(x * ceil(2^31 / 10) / 2^31), exact for x below 2^30
    localparam int                DIV10_SHIFT = 31;
    localparam logic [SUM_W-1:0]  DIV10_MULT  = SUM_W'(214748365);
    localparam logic [SUM_W-1:0]  ROUND_HALF  = SUM_W'(5);

    localparam logic [RUN_W-1:0] RUN_SAT = '1;

    typedef enum logic {
        OP_REPORT  = 1'b0,
        OP_RESTART = 1'b1
    } t_opcode;

    typedef enum logic [IDX_W-1:0] {
        CFG_TARGET_TIME = 3'd0,
        CFG_OVER_LIMIT  = 3'd1,
        CFG_UNDER_LIMIT = 3'd2,
        CFG_OVER_RUNS   = 3'd3,
        CFG_UNDER_RUNS  = 3'd4,
        CFG_TOP_LEVEL   = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic              opcode;
        logic [TIME_W-1:0] frame_time;
    } t_in_item;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               level_changed;
        logic [AVG_W-1:0]   average_time;
        logic               below_top;
    } t_out_item;

    typedef struct packed {
        logic [TIME_W-1:0]  target_time;
        logic [TIME_W-1:0]  over_limit;
        logic [TIME_W-1:0]  under_limit;
        logic [RUN_W-1:0]   over_runs;
        logic [RUN_W-1:0]   under_runs;
        logic [LEVEL_W-1:0] top_level;
    } t_cfg;

    typedef struct packed {
        logic [AVG_W-1:0]   smoothed_time;
        logic [LEVEL_W-1:0] level_index;
        logic [RUN_W-1:0]   over_count;
        logic [RUN_W-1:0]   under_count;
    } t_gov_state;

    localparam t_cfg CFG_RESET = '{
        target_time: TIME_W'(4267),
        over_limit:  TIME_W'(4693),
        under_limit: TIME_W'(3413),
        over_runs:   RUN_W'(3),
        under_runs:  RUN_W'(30),
        top_level:   LEVEL_W'(3)
    };

    // top level clamped to the table
    function automatic logic [LEVEL_W-1:0] eff_top(input logic [LEVEL_W-1:0] top);
        logic [CMP_W-1:0] t;
        t = CMP_W'(top);
        return (t > LEVEL_MAX) ? LEVEL_MAX[LEVEL_W-1:0] : top;
    endfunction

endpackage

`default_nettype wire

### src/frame_time_level_governor_core.sv
// accepted items are registered at the input, their results at the output; one
// transaction per cycle while i_out_ready is high; the smoothed time feeds into the
// next update through one registered state word, so back to back reports chain each
// cycle; reset (i_rst_n low, synchronous): config, state and valid registers take
// defaults, average seeded with the default target time, level with the top level
`default_nettype none

module frame_time_level_governor_core (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire [ftlg_pkg::IDX_W-1:0]         i_cfg_index,
    input  wire [ftlg_pkg::TIME_W-1:0]        i_cfg_data,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire ftlg_pkg::t_in_item           i_in_data,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output ftlg_pkg::t_out_item               o_out_data
);

    ftlg_pkg::t_cfg       r_cfg;
    ftlg_pkg::t_gov_state r_state;
    ftlg_pkg::t_gov_state w_state_next;
    ftlg_pkg::t_out_item  w_result;
    ftlg_pkg::t_in_item   r_in_data;
    ftlg_pkg::t_out_item  r_out_data;
    logic                 r_in_valid;
    logic                 r_out_valid;
    logic                 w_adv;

    // input register moves to the result register when that one is free or drains
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= ftlg_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (ftlg_pkg::t_cfg_index'(i_cfg_index))
                ftlg_pkg::CFG_TARGET_TIME: r_cfg.target_time <= i_cfg_data;
                ftlg_pkg::CFG_OVER_LIMIT:  r_cfg.over_limit  <= i_cfg_data;
                ftlg_pkg::CFG_UNDER_LIMIT: r_cfg.under_limit <= i_cfg_data;
                ftlg_pkg::CFG_OVER_RUNS:   r_cfg.over_runs   <= i_cfg_data[ftlg_pkg::RUN_W-1:0];
                ftlg_pkg::CFG_UNDER_RUNS:  r_cfg.under_runs  <= i_cfg_data[ftlg_pkg::RUN_W-1:0];
                ftlg_pkg::CFG_TOP_LEVEL:   r_cfg.top_level   <= i_cfg_data[ftlg_pkg::LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    ftlg_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (r_in_data),
        .o_state  (w_state_next),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.smoothed_time <= {ftlg_pkg::CFG_RESET.target_time, 8'h00};
            r_state.level_index   <= ftlg_pkg::eff_top(ftlg_pkg::CFG_RESET.top_level);
            r_state.over_count    <= '0;
            r_state.under_count   <= '0;
            r_in_valid            <= 1'b0;
            r_out_valid           <= 1'b0;
        end else begin
            if (w_adv) begin
                r_state <= w_state_next;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            r_out_valid <= w_adv || (r_out_valid && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
        if (w_adv) begin
            r_out_data <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // state only moves when a transaction is processed
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_state))
        else $error("governor state changed without a transaction");

    // restart reseeds the average and never reports a step
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_in_data.opcode == ftlg_pkg::OP_RESTART |=>
            !r_out_data.level_changed &&
            r_out_data.average_time == {$past(r_cfg.target_time), 8'h00})
        else $error("restart result wrong");

    // a report moves the level by at most one
    a_single_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_in_data.opcode == ftlg_pkg::OP_REPORT |=>
            r_state.level_index == $past(r_state.level_index) ||
            r_state.level_index == $past(r_state.level_index) + 1'b1 ||
            r_state.level_index == $past(r_state.level_index) - 1'b1)
        else $error("level moved by more than one");

    // a step leaves both run counters cleared
    a_step_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && w_result.level_changed |=>
            r_state.over_count == '0 && r_state.under_count == '0)
        else $error("run counter not cleared after a step");

endmodule

`default_nettype wire

### src/ftlg_step.sv
`default_nettype none

module ftlg_step (
    input  wire ftlg_pkg::t_gov_state i_state,
    input  wire ftlg_pkg::t_cfg       i_cfg,
    input  wire ftlg_pkg::t_in_item   i_item,
    output ftlg_pkg::t_gov_state      o_state,
    output ftlg_pkg::t_out_item       o_result
);

    logic [ftlg_pkg::SUM_W-1:0]     w_sum;
    logic [2*ftlg_pkg::SUM_W-1:0]   w_prod;
    logic [ftlg_pkg::AVG_W-1:0]     w_avg;
    logic [ftlg_pkg::LEVEL_W-1:0]   w_top;
    logic [ftlg_pkg::CMP_W-1:0]     w_floor;
    logic [ftlg_pkg::CMP_W-1:0]     w_level;
    logic [ftlg_pkg::RUN_W-1:0]     w_over_inc;
    logic [ftlg_pkg::RUN_W-1:0]     w_under_inc;
    logic                           w_over;
    logic                           w_under;
    logic                           w_changed;
    ftlg_pkg::t_gov_state           w_next;

    // 9 * old + (frame << 8) + 5, then one tenth by reciprocal
    assign w_sum = ftlg_pkg::SUM_W'({i_state.smoothed_time, 3'b000})
                 + ftlg_pkg::SUM_W'(i_state.smoothed_time)
                 + ftlg_pkg::SUM_W'({i_item.frame_time, 8'h00})
                 + ftlg_pkg::ROUND_HALF;
    assign w_prod = w_sum * ftlg_pkg::DIV10_MULT;
    assign w_avg  = w_prod[ftlg_pkg::DIV10_SHIFT +: ftlg_pkg::AVG_W];

    assign w_top   = ftlg_pkg::eff_top(i_cfg.top_level);
    assign w_floor = (ftlg_pkg::CMP_W'(w_top) >= ftlg_pkg::NATIVE_LVL)
                   ? ftlg_pkg::NATIVE_LVL : '0;
    assign w_level = ftlg_pkg::CMP_W'(i_state.level_index);

    assign w_over  = w_avg > {i_cfg.over_limit, 8'h00};
    assign w_under = w_avg < {i_cfg.under_limit, 8'h00};

    assign w_over_inc  = (i_state.over_count == ftlg_pkg::RUN_SAT)
                       ? i_state.over_count : i_state.over_count + 1'b1;
    assign w_under_inc = (i_state.under_count == ftlg_pkg::RUN_SAT)
                       ? i_state.under_count : i_state.under_count + 1'b1;

    always_comb begin
        w_next    = i_state;
        w_changed = 1'b0;
        if (i_item.opcode == ftlg_pkg::OP_RESTART) begin
            w_next.smoothed_time = {i_cfg.target_time, 8'h00};
            w_next.level_index   = w_top;
            w_next.over_count    = '0;
            w_next.under_count   = '0;
        end else begin
            w_next.smoothed_time = w_avg;
            if (w_over) begin
                w_next.over_count  = w_over_inc;
                w_next.under_count = '0;
                // a zero run setting acts like one since the count is at least one here
                if (w_over_inc >= i_cfg.over_runs && w_level > w_floor) begin
                    w_next.level_index = i_state.level_index - 1'b1;
                    w_next.over_count  = '0;
                    w_changed          = 1'b1;
                end
            end else if (w_under) begin
                w_next.under_count = w_under_inc;
                w_next.over_count  = '0;
                if (w_under_inc >= i_cfg.under_runs && i_state.level_index < w_top) begin
                    w_next.level_index = i_state.level_index + 1'b1;
                    w_next.under_count = '0;
                    w_changed          = 1'b1;
                end
            end else begin
                w_next.over_count  = '0;
                w_next.under_count = '0;
            end
        end
    end

    assign o_state                = w_next;
    assign o_result.level         = w_next.level_index;
    assign o_result.level_changed = w_changed;
    assign o_result.average_time  = w_next.smoothed_time;
    assign o_result.below_top     = w_next.level_index < w_top;

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import ftlg_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int RAND_PHASES = 12;

    // keeps the expected level, counters and smoothed time in step with the dut
    class level_scoreboard;
        t_cfg       regs;
        t_gov_state st;
        t_out_item  want_q[$];
        int         errors;
        int         results;
        int         steps;
        int         restarts;

        function new();
            regs     = CFG_RESET;
            errors   = 0;
            results  = 0;
            steps    = 0;
            restarts = 0;
            restart_state();
        endfunction

        function logic [LEVEL_W-1:0] top_index();
            if (int'(regs.top_level) > LEVELS - 1) return LEVEL_W'(LEVELS - 1);
            return regs.top_level;
        endfunction

        function logic [LEVEL_W-1:0] floor_index();
            return (int'(top_index()) >= NATIVE_INDEX) ? LEVEL_W'(NATIVE_INDEX) : '0;
        endfunction

        function void restart_state();
            st.smoothed_time = {regs.target_time, 8'h00};
            st.level_index   = top_index();
            st.over_count    = '0;
            st.under_count   = '0;
        endfunction

        function void note_write(t_cfg_index idx, logic [TIME_W-1:0] v);
            case (idx)
                CFG_TARGET_TIME: regs.target_time = v;
                CFG_OVER_LIMIT:  regs.over_limit  = v;
                CFG_UNDER_LIMIT: regs.under_limit = v;
                CFG_OVER_RUNS:   regs.over_runs   = v[RUN_W-1:0];
                CFG_UNDER_RUNS:  regs.under_runs  = v[RUN_W-1:0];
                CFG_TOP_LEVEL:   regs.top_level   = v[LEVEL_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_item(t_in_item it);
            logic [31:0] acc;
            logic        stepped;
            t_out_item   want;
            stepped = 1'b0;
            if (it.opcode == OP_RESTART) begin
                restart_state();
                restarts++;
            end else begin
                // one tenth weight, rounded to nearest
                acc = 32'd9 * 32'(st.smoothed_time) + (32'(it.frame_time) << 8) + 32'd5;
                st.smoothed_time = AVG_W'(acc / 32'd10);
                if (st.smoothed_time > {regs.over_limit, 8'h00}) begin
                    if (st.over_count != RUN_SAT) st.over_count = st.over_count + 1'b1;
                    st.under_count = '0;
                    if (st.over_count >= regs.over_runs && st.level_index > floor_index()) begin
                        st.level_index = st.level_index - 1'b1;
                        st.over_count  = '0;
                        stepped        = 1'b1;
                    end
                end else if (st.smoothed_time < {regs.under_limit, 8'h00}) begin
                    if (st.under_count != RUN_SAT) st.under_count = st.under_count + 1'b1;
                    st.over_count = '0;
                    if (st.under_count >= regs.under_runs && st.level_index < top_index()) begin
                        st.level_index = st.level_index + 1'b1;
                        st.under_count = '0;
                        stepped        = 1'b1;
                    end
                end else begin
                    st.over_count  = '0;
                    st.under_count = '0;
                end
            end
            want.level         = st.level_index;
            want.level_changed = stepped;
            want.average_time  = st.smoothed_time;
            want.below_top     = (st.level_index < top_index());
            if (stepped) steps++;
            want_q.push_back(want);
        endfunction

        function void mismatch(string field, logic [AVG_W-1:0] want, logic [AVG_W-1:0] got);
            $display("%0t %s: expected %0h, got %0h", $time, field, want, got);
            errors++;
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (want_q.size() == 0) begin
                $display("%0t result with nothing expected: %p", $time, got);
                errors++;
                return;
            end
            want = want_q.pop_front();
            results++;
            if (got.level !== want.level)
                mismatch("level", AVG_W'(want.level), AVG_W'(got.level));
            if (got.level_changed !== want.level_changed)
                mismatch("level_changed", AVG_W'(want.level_changed),
                         AVG_W'(got.level_changed));
            if (got.average_time !== want.average_time)
                mismatch("average_time", want.average_time, got.average_time);
            if (got.below_top !== want.below_top)
                mismatch("below_top", AVG_W'(want.below_top), AVG_W'(got.below_top));
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    t_cfg_index        cfg_index = CFG_TARGET_TIME;
    logic [TIME_W-1:0] cfg_data = '0;
    logic              in_valid = 1'b0;
    t_in_item          in_data = '0;
    logic              out_ready = 1'b0;
    logic              o_in_ready;
    logic              o_out_valid;
    t_out_item         o_out_data;
    bit                calm = 1'b0;
    int                quiet = 0;
    int                n_writes = 0;

    level_scoreboard gov = new();

    frame_time_level_governor_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        out_ready <= calm || ($urandom_range(99) >= 16);
    end

    always @(posedge clk) begin
        if (rst_n && o_out_valid && out_ready) gov.check_result(o_out_data);
        if (!rst_n || cfg_we || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("%0t no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("tb NOT OK");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic send_item(input t_in_item it);
        while (!calm && $urandom_range(99) < 16) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!o_in_ready) @(posedge clk);
        gov.note_item(it);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [TIME_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        gov.note_write(idx, v);
        n_writes++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // stop sending and let every outstanding result come back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (gov.want_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [RUN_W-1:0] run_count();
        int r;
        r = $urandom_range(9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return RUN_W'($urandom_range(1, 12));
    endfunction

    task automatic random_regs();
        logic [TIME_W-1:0]  tgt;
        logic [TIME_W-1:0]  ovr;
        logic [TIME_W-1:0]  und;
        logic [LEVEL_W-1:0] top;
        int                 r;
        r   = $urandom_range(9);
        ovr = TIME_W'($urandom_range(1500, 9000));
        und = TIME_W'(int'(ovr) - int'($urandom_range(0, 1500)));
        tgt = TIME_W'($urandom_range(1000, 10000));
        top = LEVEL_W'($urandom);
        if (r == 0) begin
            ovr = '0;
            und = '1;
        end else if (r == 1) begin
            ovr = '1;
            und = '0;
            tgt = '1;
        end else if (r == 2) begin
            // over limit below under limit
            und = ovr + TIME_W'($urandom_range(1, 800));
        end
        write_reg(CFG_TARGET_TIME, tgt);
        write_reg(CFG_OVER_LIMIT, ovr);
        write_reg(CFG_UNDER_LIMIT, und);
        write_reg(CFG_OVER_RUNS, {8'($urandom), run_count()});
        write_reg(CFG_UNDER_RUNS, {8'($urandom), run_count()});
        write_reg(CFG_TOP_LEVEL, {13'($urandom), top});
    endtask

    function automatic logic [TIME_W-1:0] near_limit(logic [TIME_W-1:0] lim, bit above);
        int off;
        int v;
        off = $urandom_range(0, 2304);
        v   = above ? int'(lim) + off - 256 : int'(lim) - off + 256;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return TIME_W'(v);
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        int       r;
        int       lo;
        int       hi;
        r             = $urandom_range(99);
        it.opcode     = OP_REPORT;
        it.frame_time = TIME_W'($urandom);
        if (r < 4) begin
            it.opcode = OP_RESTART;
        end else if (r < 40) begin
            it.frame_time = near_limit(gov.regs.over_limit, 1'b1);
        end else if (r < 76) begin
            it.frame_time = near_limit(gov.regs.under_limit, 1'b0);
        end else if (r < 90) begin
            lo = int'(gov.regs.under_limit);
            hi = int'(gov.regs.over_limit);
            it.frame_time = TIME_W'($urandom_range(lo, hi));
        end
        return it;
    endfunction

    initial begin
        int phase;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: already at the floor, over-budget run keeps counting
        send_item(t_in_item'{OP_REPORT, 16'h0000});
        repeat (4) send_item(t_in_item'{OP_REPORT, 16'hFFFF});
        send_item(t_in_item'{OP_RESTART, 16'hFFFF});
        send_item(t_in_item'{OP_REPORT, 16'h8000});

        // zero run lengths and overlapping limits, over test wins
        settle();
        write_reg(CFG_TARGET_TIME, 16'h0000);
        write_reg(CFG_OVER_LIMIT, 16'h0000);
        write_reg(CFG_UNDER_LIMIT, 16'hFFFF);
        write_reg(CFG_OVER_RUNS, 16'h0000);
        write_reg(CFG_UNDER_RUNS, 16'h0000);
        write_reg(CFG_TOP_LEVEL, 16'h0007);
        send_item(t_in_item'{OP_RESTART, 16'h0000});
        send_item(t_in_item'{OP_REPORT, 16'h0000});
        repeat (5) send_item(t_in_item'{OP_REPORT, 16'hFFFF});

        // top lowered under the current level, floor drops to zero
        settle();
        write_reg(CFG_TOP_LEVEL, 16'h0002);
        repeat (3) send_item(t_in_item'{OP_REPORT, 16'hFFFF});

        // largest target and limits
        settle();
        write_reg(CFG_TARGET_TIME, 16'hFFFF);
        write_reg(CFG_OVER_LIMIT, 16'hFFFF);
        write_reg(CFG_UNDER_LIMIT, 16'hFFFF);
        write_reg(CFG_OVER_RUNS, 16'hFFFF);
        write_reg(CFG_UNDER_RUNS, 16'h0001);
        send_item(t_in_item'{OP_RESTART, 16'h1234});
        send_item(t_in_item'{OP_REPORT, 16'hFFFF});
        repeat (2) send_item(t_in_item'{OP_REPORT, 16'h0000});

        // under-budget run saturates with no room, then a raised top lets it step
        settle();
        write_reg(CFG_TARGET_TIME, 16'h0000);
        write_reg(CFG_OVER_LIMIT, 16'hFFFF);
        write_reg(CFG_UNDER_LIMIT, 16'hFFFF);
        write_reg(CFG_OVER_RUNS, 16'h0003);
        write_reg(CFG_UNDER_RUNS, 16'h00FF);
        write_reg(CFG_TOP_LEVEL, 16'h0002);
        send_item(t_in_item'{OP_RESTART, 16'h0000});
        repeat (300) send_item(t_in_item'{OP_REPORT, TIME_W'($urandom)});
        settle();
        write_reg(CFG_TOP_LEVEL, 16'h0005);
        repeat (4) send_item(t_in_item'{OP_REPORT, TIME_W'($urandom)});

        for (phase = 0; phase < RAND_PHASES; phase++) begin
            settle();
            random_regs();
            calm = (phase == 5);
            repeat (120) send_item(random_item());
        end
        settle();
        calm = 1'b0;
        repeat (4) @(posedge clk);

        $display("%0d results checked, %0d level steps, %0d restarts, %0d register writes",
                 gov.results, gov.steps, gov.restarts, n_writes);
        $display("directed corners, a saturated run counter and %0d random settings",
                 RAND_PHASES);
        if (gov.errors == 0 && gov.want_q.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
